// ----- rtl/core/brr_pkg.sv -----
// Shared types and constants for the bilinear RGB resampler.
package brr_pkg;

    localparam int COORD_W     = 12;
    localparam int CHAN_W      = 8;
    localparam int PIX_W       = 3 * CHAN_W;
    localparam int SIZE_W      = 9;
    localparam int STEP_W      = 24;
    localparam int FRAC_BITS   = 16;
    localparam int POS_W       = COORD_W + STEP_W;
    localparam int WGT_W       = FRAC_BITS + 1;
    localparam int ROWSUM_W    = CHAN_W + FRAC_BITS;
    localparam int PROD_W      = ROWSUM_W + WGT_W;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 24;

    localparam int STORE_WIDTH_DEF  = 256;
    localparam int STORE_HEIGHT_DEF = 256;

    localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(256);
    localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(65536);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SRC_WIDTH  = 3'd0,
        CFG_SRC_HEIGHT = 3'd1,
        CFG_X_STEP     = 3'd2,
        CFG_Y_STEP     = 3'd3
    } t_cfg_idx;

    typedef enum logic {
        KIND_LOAD    = 1'b0,
        KIND_REQUEST = 1'b1
    } t_kind;

    typedef struct packed {
        t_kind               kind;
        logic [COORD_W-1:0]  col;
        logic [COORD_W-1:0]  line;
        logic [CHAN_W-1:0]   red_in;
        logic [CHAN_W-1:0]   green_in;
        logic [CHAN_W-1:0]   blue_in;
    } t_in_item;

    typedef struct packed {
        logic [CHAN_W-1:0] red_out;
        logic [CHAN_W-1:0] green_out;
        logic [CHAN_W-1:0] blue_out;
    } t_out_item;

endpackage

// ----- rtl/core/bilinear_rgb_resampler_top.sv -----
// Bilinear RGB888 resampler: banked frame store and seven-stage blend pipeline.
// Each accepted request gives one result at the output; loads give none.
// Throughput: one item per cycle while the output is not stalled; the frame store is split
// into four banks by column and row parity so the four neighbours are read in parallel.
// A stalled output freezes the whole pipeline in place.
// Reset (synchronous, active low) clears valids and restores the size and step registers;
// the frame store is not cleared.
module bilinear_rgb_resampler_top #(
    parameter int STORE_WIDTH  = brr_pkg::STORE_WIDTH_DEF,
    parameter int STORE_HEIGHT = brr_pkg::STORE_HEIGHT_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  brr_pkg::t_in_item                 i_data,
    output logic                              o_valid,
    input  logic                              i_stall,
    output brr_pkg::t_out_item                o_data,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [brr_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [brr_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    localparam int BANK_W  = (STORE_WIDTH + 1) / 2;
    localparam int BANK_H  = (STORE_HEIGHT + 1) / 2;
    localparam int BANK_D  = BANK_W * BANK_H;
    localparam int AW      = (BANK_D > 1) ? $clog2(BANK_D) : 1;
    localparam int SW      = brr_pkg::SIZE_W;
    localparam int FB      = brr_pkg::FRAC_BITS;
    localparam int CW      = brr_pkg::CHAN_W;
    localparam int BASE_W  = brr_pkg::POS_W - FB;

    // configuration
    logic [SW-1:0]              r_src_w, r_src_h;
    logic [brr_pkg::STEP_W-1:0] r_x_step, r_y_step;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_w  <= brr_pkg::SIZE_RESET;
            r_src_h  <= brr_pkg::SIZE_RESET;
            r_x_step <= brr_pkg::STEP_RESET;
            r_y_step <= brr_pkg::STEP_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                brr_pkg::CFG_SRC_WIDTH:  r_src_w  <= i_cfg_data[SW-1:0];
                brr_pkg::CFG_SRC_HEIGHT: r_src_h  <= i_cfg_data[SW-1:0];
                brr_pkg::CFG_X_STEP:     r_x_step <= i_cfg_data;
                brr_pkg::CFG_Y_STEP:     r_y_step <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // effective sizes
    logic [SW-1:0] eff_w, eff_h;
    always_comb begin
        if (r_src_w == '0)                  eff_w = SW'(1);
        else if (32'(r_src_w) > STORE_WIDTH) eff_w = SW'(STORE_WIDTH);
        else                                eff_w = r_src_w;
        if (r_src_h == '0)                   eff_h = SW'(1);
        else if (32'(r_src_h) > STORE_HEIGHT) eff_h = SW'(STORE_HEIGHT);
        else                                 eff_h = r_src_h;
    end

    // handshake: the whole pipeline advances unless a held result is stalled
    logic r_ov;
    logic en, accept;
    assign o_stall = r_ov && i_stall;
    assign en      = !o_stall;
    assign accept  = i_valid && !o_stall;

    // stage 1: capture request
    logic              r1_v;
    brr_pkg::t_in_item r1_d;

    // stage 2: source positions
    logic                        r2_v;
    brr_pkg::t_kind              r2_kind;
    logic [brr_pkg::COORD_W-1:0] r2_col, r2_line;
    logic [brr_pkg::PIX_W-1:0]   r2_pix;
    logic [brr_pkg::POS_W-1:0]   r2_px, r2_py;

    // stage 3: clamped indices and fractions
    logic                        r3_v;
    brr_pkg::t_kind              r3_kind;
    logic [brr_pkg::COORD_W-1:0] r3_col, r3_line;
    logic [brr_pkg::PIX_W-1:0]   r3_pix;
    logic [SW-1:0]               r3_x0, r3_x1, r3_y0, r3_y1;
    logic [FB-1:0]               r3_fx, r3_fy;

    logic [BASE_W-1:0] bx, by;
    logic [SW-1:0]     n_x0, n_x1, n_y0, n_y1;
    logic [FB-1:0]     n_fx, n_fy;

    always_comb begin
        bx = r2_px[brr_pkg::POS_W-1:FB];
        by = r2_py[brr_pkg::POS_W-1:FB];
        if (bx >= BASE_W'(eff_w)) begin
            n_x0 = eff_w - SW'(1);
            n_fx = '0;
        end else begin
            n_x0 = bx[SW-1:0];
            n_fx = r2_px[FB-1:0];
        end
        if (by >= BASE_W'(eff_h)) begin
            n_y0 = eff_h - SW'(1);
            n_fy = '0;
        end else begin
            n_y0 = by[SW-1:0];
            n_fy = r2_py[FB-1:0];
        end
        n_x1 = ((SW+1)'(n_x0) + (SW+1)'(1) < (SW+1)'(eff_w)) ? n_x0 + SW'(1) : n_x0;
        n_y1 = ((SW+1)'(n_y0) + (SW+1)'(1) < (SW+1)'(eff_h)) ? n_y0 + SW'(1) : n_y0;
    end

    // frame store banks, indexed {row parity, column parity}
    logic                      bank_we    [4];
    logic [AW-1:0]             bank_waddr;
    logic [AW-1:0]             bank_raddr [4];
    logic [brr_pkg::PIX_W-1:0] bank_q     [4];
    logic                      load_ok;
    logic [SW-1:0]             cx [4];
    logic [SW-1:0]             cy [4];

    assign load_ok = r3_v && (r3_kind == brr_pkg::KIND_LOAD)
                     && (32'(r3_col) < STORE_WIDTH) && (32'(r3_line) < STORE_HEIGHT);
    assign bank_waddr = AW'(32'(r3_line >> 1) * BANK_W + 32'(r3_col >> 1));

    always_comb begin
        for (int b = 0; b < 4; b++) begin
            cx[b] = (r3_x0[0] == b[0]) ? r3_x0 : r3_x1;
            cy[b] = (r3_y0[0] == b[1]) ? r3_y0 : r3_y1;
            bank_raddr[b] = AW'(32'(cy[b] >> 1) * BANK_W + 32'(cx[b] >> 1));
            bank_we[b] = en && load_ok && (r3_line[0] == b[1]) && (r3_col[0] == b[0]);
        end
    end

    for (genvar g = 0; g < 4; g++) begin : g_bank
        brr_ram #(
            .WIDTH(brr_pkg::PIX_W),
            .DEPTH(BANK_D),
            .AW   (AW)
        ) u_bank (
            .i_clk  (i_clk),
            .i_we   (bank_we[g]),
            .i_waddr(bank_waddr),
            .i_wdata(r3_pix),
            .i_re   (en),
            .i_raddr(bank_raddr[g]),
            .o_rdata(bank_q[g])
        );
    end

    // stage 4: RAM data arrives with its sideband
    logic          r4_v;
    logic          r4_x0p, r4_x1p, r4_y0p, r4_y1p;
    logic [FB-1:0] r4_fx, r4_fy;

    // stage 5: horizontal blends
    logic                          r5_v;
    logic [FB-1:0]                 r5_fy;
    logic [brr_pkg::ROWSUM_W-1:0]  r5_top [3];
    logic [brr_pkg::ROWSUM_W-1:0]  r5_bot [3];

    logic [brr_pkg::PIX_W-1:0]     p00, p10, p01, p11;
    logic [brr_pkg::WGT_W-1:0]     wx0;
    logic [brr_pkg::ROWSUM_W-1:0]  n_top [3];
    logic [brr_pkg::ROWSUM_W-1:0]  n_bot [3];

    always_comb begin
        p00 = bank_q[{r4_y0p, r4_x0p}];
        p10 = bank_q[{r4_y0p, r4_x1p}];
        p01 = bank_q[{r4_y1p, r4_x0p}];
        p11 = bank_q[{r4_y1p, r4_x1p}];
        wx0 = brr_pkg::WGT_W'(65536) - brr_pkg::WGT_W'(r4_fx);
        for (int c = 0; c < 3; c++) begin
            n_top[c] = brr_pkg::ROWSUM_W'(p00[8*(2-c) +: CW]) * brr_pkg::ROWSUM_W'(wx0)
                       + brr_pkg::ROWSUM_W'(p10[8*(2-c) +: CW]) * brr_pkg::ROWSUM_W'(r4_fx);
            n_bot[c] = brr_pkg::ROWSUM_W'(p01[8*(2-c) +: CW]) * brr_pkg::ROWSUM_W'(wx0)
                       + brr_pkg::ROWSUM_W'(p11[8*(2-c) +: CW]) * brr_pkg::ROWSUM_W'(r4_fx);
        end
    end

    // stage 6: vertical products
    logic                         r6_v;
    logic [brr_pkg::PROD_W-1:0]   r6_pt [3];
    logic [brr_pkg::PROD_W-1:0]   r6_pb [3];
    logic [brr_pkg::WGT_W-1:0]    wy0;
    assign wy0 = brr_pkg::WGT_W'(65536) - brr_pkg::WGT_W'(r5_fy);

    // output: sum and round once
    brr_pkg::t_out_item           r_od;
    logic [brr_pkg::PROD_W:0]     sum [3];
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            sum[c] = (brr_pkg::PROD_W+1)'(r6_pt[c]) + (brr_pkg::PROD_W+1)'(r6_pb[c])
                     + (brr_pkg::PROD_W+1)'(64'd1 << 31);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
            r5_v <= 1'b0;
            r6_v <= 1'b0;
            r_ov <= 1'b0;
        end else if (en) begin
            r1_v <= accept;
            r2_v <= r1_v;
            r3_v <= r2_v;
            r4_v <= r3_v && (r3_kind == brr_pkg::KIND_REQUEST);
            r5_v <= r4_v;
            r6_v <= r5_v;
            r_ov <= r6_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_d    <= i_data;
            r2_kind <= r1_d.kind;
            r2_col  <= r1_d.col;
            r2_line <= r1_d.line;
            r2_pix  <= {r1_d.red_in, r1_d.green_in, r1_d.blue_in};
            r2_px   <= brr_pkg::POS_W'(r1_d.col) * brr_pkg::POS_W'(r_x_step);
            r2_py   <= brr_pkg::POS_W'(r1_d.line) * brr_pkg::POS_W'(r_y_step);
            r3_kind <= r2_kind;
            r3_col  <= r2_col;
            r3_line <= r2_line;
            r3_pix  <= r2_pix;
            r3_x0   <= n_x0;
            r3_x1   <= n_x1;
            r3_y0   <= n_y0;
            r3_y1   <= n_y1;
            r3_fx   <= n_fx;
            r3_fy   <= n_fy;
            r4_x0p  <= r3_x0[0];
            r4_x1p  <= r3_x1[0];
            r4_y0p  <= r3_y0[0];
            r4_y1p  <= r3_y1[0];
            r4_fx   <= r3_fx;
            r4_fy   <= r3_fy;
            r5_fy   <= r4_fy;
            for (int c = 0; c < 3; c++) begin
                r5_top[c] <= n_top[c];
                r5_bot[c] <= n_bot[c];
                r6_pt[c]  <= brr_pkg::PROD_W'(r5_top[c]) * brr_pkg::PROD_W'(wy0);
                r6_pb[c]  <= brr_pkg::PROD_W'(r5_bot[c]) * brr_pkg::PROD_W'(r5_fy);
            end
            r_od.red_out   <= sum[0][32 +: CW];
            r_od.green_out <= sum[1][32 +: CW];
            r_od.blue_out  <= sum[2][32 +: CW];
        end
    end

    assign o_valid = r_ov;
    assign o_data  = r_od;

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("input stalled with no result held");

    a_request_reaches_ram: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (en && r3_v && r3_kind == brr_pkg::KIND_REQUEST) |=> r4_v)
        else $error("request lost before frame store read");

    a_last_stage_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (en && r6_v) |=> o_valid)
        else $error("blend result not presented");

endmodule

// ----- rtl/core/brr_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module brr_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 16384,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
